[hw/rtl/trps_pkg.sv]
// Package with the shared types and codes of the timed-release packet slot table.
`default_nettype none

package trps_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN = 3'd0,
    ST_FULL    = 3'd1,
    ST_ZERO    = 3'd2,
    ST_NONE    = 3'd3,
    ST_OK      = 3'd4,
    ST_DROP    = 3'd5
  } status_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WSCAN,
    S_RSCAN,
    S_RTAIL,
    S_RRES
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]   release_time;
    logic [LEN_W-1:0]    packet_length;
    logic [HANDLE_W-1:0] buffer_handle;
  } entry_t;

  typedef struct packed {
    logic due;
    logic better;
  } cmp_res_t;

endpackage

`default_nettype wire

[hw/rtl/trps_mem.sv]
// Descriptor storage with one write port and one registered read port.
`default_nettype none

module trps_mem #(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IW-1:0]     waddr,
  input  wire trps_pkg::entry_t  wdata,
  input  wire logic              re,
  input  wire logic [IW-1:0]     raddr,
  output trps_pkg::entry_t       rdata
);

  trps_pkg::entry_t mem [SLOTS];
  trps_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/trps_cmp.sv]
// Shared compare unit that checks one stored release time against now and the best so far.
`default_nettype none

module trps_cmp (
  input  wire logic [trps_pkg::TIME_W-1:0] cand,
  input  wire logic [trps_pkg::TIME_W-1:0] now_time,
  input  wire logic [trps_pkg::TIME_W-1:0] best,
  output trps_pkg::cmp_res_t               res
);

  always_comb begin
    res.due    = (cand <= now_time);
    res.better = (cand < best);
  end

endmodule

`default_nettype wire

[hw/rtl/timed_release_packet_slots.sv]
// Top level of the timed-release packet slot table with its scan sequencer.
//
//   Channel   Handshake            Ports
//   input     start & !busy        in_mode, in_now_time, in_release_time,
//                                  in_packet_length, in_buffer_handle, in_receive_capacity
//   result    out_valid (1 cycle)  out_status, out_slot_index, out_delivered_length,
//                                  out_delivered_handle, out_occupied_count
//
// A zero-length write or a write to a full table is answered in the cycle after acceptance.
// Another write visits the slots in order, up to and including the first free slot.
// A read does one descriptor read per slot, then the last compare in the tail state
// and the result in the result state.
// Reset clears all slots at once through the occupancy flip-flops; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module timed_release_packet_slots #(
  parameter int SLOTS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_mode,
  input  wire logic [trps_pkg::TIME_W-1:0]       in_now_time,
  input  wire logic [trps_pkg::TIME_W-1:0]       in_release_time,
  input  wire logic [trps_pkg::LEN_W-1:0]        in_packet_length,
  input  wire logic [trps_pkg::HANDLE_W-1:0]     in_buffer_handle,
  input  wire logic [trps_pkg::LEN_W-1:0]        in_receive_capacity,
  output logic                                   out_valid,
  output logic [trps_pkg::STATUS_W-1:0]          out_status,
  output logic [trps_pkg::SLOT_W-1:0]            out_slot_index,
  output logic [trps_pkg::LEN_W-1:0]             out_delivered_length,
  output logic [trps_pkg::HANDLE_W-1:0]          out_delivered_handle,
  output logic [trps_pkg::OCC_W-1:0]             out_occupied_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  trps_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SLOTS-1:0] busy_r, busy_nxt;

  logic [trps_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [trps_pkg::TIME_W-1:0]   rel_r, rel_nxt;
  logic [trps_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [trps_pkg::HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic [trps_pkg::LEN_W-1:0]    cap_r, cap_nxt;

  logic          ev_vld_r, ev_vld_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;

  logic                          found_r, found_nxt;
  logic [IW-1:0]                 best_idx_r, best_idx_nxt;
  logic [trps_pkg::TIME_W-1:0]   best_rel_r, best_rel_nxt;
  logic [trps_pkg::LEN_W-1:0]    best_len_r, best_len_nxt;
  logic [trps_pkg::HANDLE_W-1:0] best_hnd_r, best_hnd_nxt;

  logic                          out_valid_r, out_valid_nxt;
  trps_pkg::status_t             out_status_r, out_status_nxt;
  logic [trps_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [trps_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [trps_pkg::HANDLE_W-1:0] out_hnd_r, out_hnd_nxt;
  logic [trps_pkg::OCC_W-1:0]    out_occ_r, out_occ_nxt;

  logic          accept;
  logic          table_full;
  logic          scan_last;
  logic [IW-1:0] scan_idx;
  logic          ws_free;

  logic             mem_we;
  logic             mem_re;
  trps_pkg::entry_t mem_wdata;
  trps_pkg::entry_t mem_rdata;

  trps_pkg::cmp_res_t cmp_res;

  logic [IW+trps_pkg::SLOT_W-1:0] slot_wide_w, slot_wide_r;
  logic [CW+trps_pkg::OCC_W-1:0]  occ_wide;

  assign accept     = start && (state_r == trps_pkg::S_IDLE);
  assign table_full = (cnt_r == CW'(SLOTS));
  assign scan_idx   = scan_r[IW-1:0];
  assign scan_last  = (scan_r == CW'(SLOTS - 1));
  assign ws_free    = !busy_r[scan_idx];

  assign slot_wide_w = {{trps_pkg::SLOT_W{1'b0}}, scan_idx};
  assign slot_wide_r = {{trps_pkg::SLOT_W{1'b0}}, best_idx_r};

  assign mem_wdata.release_time  = rel_r;
  assign mem_wdata.packet_length = len_r;
  assign mem_wdata.buffer_handle = hnd_r;

  trps_mem #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (scan_idx),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_idx),
    .rdata (mem_rdata)
  );

  trps_cmp u_cmp (
    .cand     (mem_rdata.release_time),
    .now_time (now_r),
    .best     (best_rel_r),
    .res      (cmp_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trps_pkg::S_IDLE: begin
        if (start) begin
          if (in_mode == trps_pkg::MODE_READ) begin
            state_nxt = trps_pkg::S_RSCAN;
          end else if ((in_packet_length != '0) && !table_full) begin
            state_nxt = trps_pkg::S_WSCAN;
          end
        end
      end
      trps_pkg::S_WSCAN: begin
        if (ws_free) begin
          state_nxt = trps_pkg::S_IDLE;
        end
      end
      trps_pkg::S_RSCAN: begin
        if (scan_last) begin
          state_nxt = trps_pkg::S_RTAIL;
        end
      end
      trps_pkg::S_RTAIL: state_nxt = trps_pkg::S_RRES;
      trps_pkg::S_RRES:  state_nxt = trps_pkg::S_IDLE;
      default:           state_nxt = trps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    now_nxt       = now_r;
    rel_nxt       = rel_r;
    len_nxt       = len_r;
    hnd_nxt       = hnd_r;
    cap_nxt       = cap_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = scan_idx;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_rel_nxt  = best_rel_r;
    best_len_nxt  = best_len_r;
    best_hnd_nxt  = best_hnd_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt  = '0;
    out_len_nxt   = '0;
    out_hnd_nxt   = '0;
    out_occ_nxt   = out_occ_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (ev_vld_r && busy_r[ev_idx_r] && cmp_res.due && (!found_r || cmp_res.better)) begin
      found_nxt    = 1'b1;
      best_idx_nxt = ev_idx_r;
      best_rel_nxt = mem_rdata.release_time;
      best_len_nxt = mem_rdata.packet_length;
      best_hnd_nxt = mem_rdata.buffer_handle;
    end

    unique case (state_r)
      trps_pkg::S_IDLE: begin
        if (accept) begin
          now_nxt   = in_now_time;
          rel_nxt   = in_release_time;
          len_nxt   = in_packet_length;
          hnd_nxt   = in_buffer_handle;
          cap_nxt   = in_receive_capacity;
          scan_nxt  = '0;
          found_nxt = 1'b0;
          if (in_mode == trps_pkg::MODE_WRITE) begin
            if (in_packet_length == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = trps_pkg::ST_ZERO;
            end else if (table_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = trps_pkg::ST_FULL;
            end
          end
        end
      end
      trps_pkg::S_WSCAN: begin
        if (ws_free) begin
          mem_we             = 1'b1;
          busy_nxt[scan_idx] = 1'b1;
          cnt_nxt            = cnt_r + CW'(1);
          out_valid_nxt      = 1'b1;
          out_status_nxt     = trps_pkg::ST_WRITTEN;
          out_slot_nxt       = slot_wide_w[trps_pkg::SLOT_W-1:0];
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      trps_pkg::S_RSCAN: begin
        mem_re     = 1'b1;
        ev_vld_nxt = 1'b1;
        scan_nxt   = scan_r + CW'(1);
      end
      trps_pkg::S_RTAIL: begin
        scan_nxt = '0;
      end
      trps_pkg::S_RRES: begin
        out_valid_nxt = 1'b1;
        if (found_r) begin
          busy_nxt[best_idx_r] = 1'b0;
          cnt_nxt              = cnt_r - CW'(1);
          out_status_nxt       = (best_len_r <= cap_r) ? trps_pkg::ST_OK : trps_pkg::ST_DROP;
          out_slot_nxt         = slot_wide_r[trps_pkg::SLOT_W-1:0];
          out_len_nxt          = best_len_r;
          out_hnd_nxt          = best_hnd_r;
        end else begin
          out_status_nxt = trps_pkg::ST_NONE;
        end
      end
      default: begin
      end
    endcase

    occ_wide = {{trps_pkg::OCC_W{1'b0}}, cnt_nxt};
    if (out_valid_nxt) begin
      out_occ_nxt = occ_wide[trps_pkg::OCC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trps_pkg::S_IDLE;
      scan_r      <= '0;
      cnt_r       <= '0;
      busy_r      <= '0;
      ev_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      ev_vld_r    <= ev_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    rel_r        <= rel_nxt;
    len_r        <= len_nxt;
    hnd_r        <= hnd_nxt;
    cap_r        <= cap_nxt;
    ev_idx_r     <= ev_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_rel_r   <= best_rel_nxt;
    best_len_r   <= best_len_nxt;
    best_hnd_r   <= best_hnd_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_len_r    <= out_len_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign busy                 = (state_r != trps_pkg::S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot_index       = out_slot_r;
  assign out_delivered_length = out_len_r;
  assign out_delivered_handle = out_hnd_r;
  assign out_occupied_count   = out_occ_r;

  // The occupancy count always equals the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) == $countones(busy_r))
    else $error("occupancy count differs from the occupied slot bits");

  // A result is only presented once the sequencer has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == trps_pkg::S_IDLE))
    else $error("result strobe while a transaction is still in progress");

  // The free-slot search only runs while at least one slot is free.
  a_wscan_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trps_pkg::S_WSCAN) |-> (cnt_r < CW'(SLOTS)))
    else $error("free-slot search started on a full table");

  // A completed read scan always moves on to the compare tail.
  a_rscan_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == trps_pkg::S_RSCAN) && scan_last) |=> (state_r == trps_pkg::S_RTAIL))
    else $error("read scan did not end in the compare tail");

endmodule

`default_nettype wire
